@@ design/simplex_barycentric_interpolator_unit_defines.svh @@
// Assertion macros shared by the simplex interpolator modules.
`ifndef SIMPLEX_BARYCENTRIC_INTERPOLATOR_UNIT_DEFINES_SVH
`define SIMPLEX_BARYCENTRIC_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SBI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SBI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sbi_pkg.sv @@
// Types, codes and constants shared by the simplex interpolator modules.
package sbi_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 63;
  localparam int DET_BITS      = 64;
  localparam int OPB_BITS      = 32;
  localparam int ACC_BITS      = 128;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DIMENSION  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VOLUME_CUT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_VOLUME = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] STAT_VALID      = 2'd0;
  localparam logic [1:0] STAT_DEGENERATE = 2'd1;
  localparam logic [1:0] STAT_TOO_SMALL  = 2'd2;
  localparam logic [1:0] STAT_OUTSIDE    = 2'd3;

  localparam logic [2:0] ARITH_NOP      = 3'd0;
  localparam logic [2:0] ARITH_MUL_LO   = 3'd1;
  localparam logic [2:0] ARITH_MUL_HI   = 3'd2;
  localparam logic [2:0] ARITH_CLR      = 3'd3;
  localparam logic [2:0] ARITH_DIV_INIT = 3'd4;
  localparam logic [2:0] ARITH_DIV_STEP = 3'd5;

  typedef struct packed {
    logic               action;
    logic [1:0]         corner_slot;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic signed [63:0] element_det;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                 op;
    logic signed [DET_BITS-1:0] a;
    logic signed [OPB_BITS-1:0] b;
    logic                       sub;
  } arith_cmd_t;

endpackage

@@ design/sbi_arith.sv @@
// Shared arithmetic unit: 32x32 multiply-accumulate and restoring divider.
`include "simplex_barycentric_interpolator_unit_defines.svh"

module sbi_arith (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sbi_pkg::arith_cmd_t            cmd,
  input  logic [sbi_pkg::DET_BITS-1:0]   divisor,
  output logic [sbi_pkg::ACC_BITS-1:0]   acc
);
  import sbi_pkg::*;

  logic [DET_BITS-1:0]   mag_a;
  logic [OPB_BITS-1:0]   mag_b;
  logic [31:0]           part;
  logic [63:0]           prod_nxt, prod_r;
  logic                  psh_r, pneg_r, pv_r;
  logic                  is_mul;
  logic [ACC_BITS-1:0]   ext;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [DET_BITS-1:0]   rem_r, rem_nxt;
  logic [DET_BITS:0]     rem_sh;
  logic                  ge;

  always_comb begin
    mag_a    = cmd.a[DET_BITS-1] ? DET_BITS'(-cmd.a) : DET_BITS'(cmd.a);
    mag_b    = cmd.b[OPB_BITS-1] ? OPB_BITS'(-cmd.b) : OPB_BITS'(cmd.b);
    part     = (cmd.op == ARITH_MUL_HI) ? mag_a[63:32] : mag_a[31:0];
    prod_nxt = part * mag_b;
    is_mul   = (cmd.op == ARITH_MUL_LO) || (cmd.op == ARITH_MUL_HI);
    ext      = psh_r ? {32'b0, prod_r, 32'b0} : {64'b0, prod_r};
    rem_sh   = {rem_r, acc_r[ACC_BITS-1]};
    ge       = rem_sh >= {1'b0, divisor};
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    case (cmd.op)
      ARITH_CLR: acc_nxt = '0;
      ARITH_DIV_INIT: begin
        acc_nxt = acc_r[ACC_BITS-1] ? ACC_BITS'(-acc_r) : acc_r;
        rem_nxt = '0;
      end
      ARITH_DIV_STEP: begin
        rem_nxt = ge ? DET_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[DET_BITS-1:0];
        acc_nxt = {acc_r[ACC_BITS-2:0], ge};
      end
      default: begin
        if (pv_r) begin
          acc_nxt = pneg_r ? acc_r - ext : acc_r + ext;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    psh_r  <= (cmd.op == ARITH_MUL_HI);
    pneg_r <= cmd.a[DET_BITS-1] ^ cmd.b[OPB_BITS-1] ^ cmd.sub;
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
      rem_r <= '0;
    end else begin
      pv_r  <= is_mul;
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign acc = acc_r;

  `SBI_ASSERT_NXT(a_prod_follows_mul, is_mul, pv_r, "product stage lost a multiply")
  `SBI_ASSERT_NXT(a_clear_empties, cmd.op == ARITH_CLR, acc_r == '0, "clear left residue")
  `SBI_ASSERT_NXT(a_rem_bounded, cmd.op == ARITH_DIV_STEP && rem_r < divisor, rem_r < $past(divisor), "divider remainder escaped its bound")

endmodule

@@ design/simplex_barycentric_interpolator_unit.sv @@
// Top level of the simplex barycentric interpolator.
`include "simplex_barycentric_interpolator_unit_defines.svh"

// A load transaction (action 0) writes one corner and its field vector in the
// accepting cycle and produces no result; busy stays low. A query transaction
// (action 1) raises busy and runs a sequencer over one shared arithmetic unit
// that holds a single 32x32 multiplier, a 128-bit accumulator and a 1-bit-per-
// cycle restoring divider. Each product takes two multiplier passes. Five
// tetrahedron determinants (or four triangle determinants) are computed.
// Each field component then takes n products (n corners) and, unless the
// element determinant is zero, a 128-step division, the dominant cost. The
// result is strobed on out_valid for exactly one cycle right as busy drops;
// the receiver cannot stall it, so it must capture out_data on that cycle.
// Configuration writes are taken on any cycle but are meant only while no
// query is in flight.
module simplex_barycentric_interpolator_unit #(
  parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEF,
  parameter int VALUE_BITS = sbi_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  sbi_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  output sbi_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [sbi_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [sbi_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import sbi_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int VW = VALUE_BITS;
  localparam int DW = CW + 1;
  localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (VW - 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_ISTO  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DFIN  = 3'd6;

  // Configuration registers.
  logic [1:0]               dim_r;
  logic [CFG_DATA_BITS-1:0] cut_r, minv_r;

  // Corner storage; contents are undefined until loaded.
  logic signed [CW-1:0] cx_r [4];
  logic signed [CW-1:0] cy_r [4];
  logic signed [CW-1:0] cz_r [4];
  logic signed [VW-1:0] vx_r [4];
  logic signed [VW-1:0] vy_r [4];
  logic signed [VW-1:0] vz_r [4];

  logic [2:0] st_r, st_nxt;
  logic [2:0] dk_r, dk_nxt;
  logic [1:0] sum_r, sum_nxt;
  logic [1:0] trm_r, trm_nxt;
  logic       ph_r, ph_nxt;
  logic       mode_r, mode_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       neg_r, neg_nxt;
  logic       outside_r, outside_nxt;
  logic signed [CW-1:0] qx_r, qx_nxt, qy_r, qy_nxt, qz_r, qz_nxt;
  logic signed [DET_BITS-1:0] m1_r, m1_nxt, m2_r, m2_nxt, m3_r, m3_nxt;
  logic signed [DET_BITS-1:0] det_r, det_nxt;
  logic signed [DET_BITS-1:0] sub_r [4];
  logic signed [DET_BITS-1:0] sub_nxt [4];
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic                        tri_mode;
  logic                        accept, last_trm;
  logic [2:0]                  dk_last;
  logic signed [CW-1:0]        px [4];
  logic signed [CW-1:0]        py [4];
  logic signed [CW-1:0]        pz [4];
  logic signed [DW-1:0]        d_ax, d_ay, d_az, d_bx, d_by, d_bz, d_cx, d_cy, d_cz;
  logic signed [DET_BITS-1:0]  opa, sval;
  logic signed [OPB_BITS-1:0]  opb;
  logic                        osub;
  arith_cmd_t                  cmd;
  logic [ACC_BITS-1:0]         acc_w;
  logic [DET_BITS-1:0]         det_mag;
  logic [1:0]                  status_w, sidx;
  logic [ACC_BITS-1:0]         lim;
  logic [31:0]                 qs, res_div, res_w;

  assign tri_mode = (dim_r == 2'd2);
  assign accept   = start && !busy;
  assign dk_last  = tri_mode ? 3'd3 : 3'd4;
  assign sidx     = 2'(dk_r - 3'd1);

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= 2'd3;
      cut_r  <= '0;
      minv_r <= CFG_DATA_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIMENSION:  dim_r  <= cfg_wdata[1:0];
        CFG_VOLUME_CUT: cut_r  <= cfg_wdata;
        CFG_MIN_VOLUME: minv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Corner loads complete in the accepting cycle.
  always_ff @(posedge clk) begin
    if (accept && in_data.action == ACT_LOAD) begin
      cx_r[in_data.corner_slot] <= CW'(in_data.coord_x);
      cy_r[in_data.corner_slot] <= CW'(in_data.coord_y);
      cz_r[in_data.corner_slot] <= CW'(in_data.coord_z);
      vx_r[in_data.corner_slot] <= VW'(in_data.value_x);
      vy_r[in_data.corner_slot] <= VW'(in_data.value_y);
      vz_r[in_data.corner_slot] <= VW'(in_data.value_z);
    end
  end

  // The point set of the current determinant: the element itself when dk is
  // zero, otherwise the element with corner dk-1 replaced by the query point.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (dk_r == 3'(j + 1)) begin
        px[j] = qx_r;
        py[j] = qy_r;
        pz[j] = qz_r;
      end else begin
        px[j] = cx_r[j];
        py[j] = cy_r[j];
        pz[j] = cz_r[j];
      end
    end
    d_ax = DW'(px[1]) - DW'(px[0]);
    d_ay = DW'(py[1]) - DW'(py[0]);
    d_az = DW'(pz[1]) - DW'(pz[0]);
    d_bx = DW'(px[2]) - DW'(px[0]);
    d_by = DW'(py[2]) - DW'(py[0]);
    d_bz = DW'(pz[2]) - DW'(pz[0]);
    d_cx = DW'(px[3]) - DW'(px[0]);
    d_cy = DW'(py[3]) - DW'(py[0]);
    d_cz = DW'(pz[3]) - DW'(pz[0]);
  end

  // Operand selection. The determinant is built from three 2x2 minors and a
  // final sum of three products; a triangle needs only the third minor.
  always_comb begin
    opa  = '0;
    opb  = '0;
    osub = 1'b0;
    if (mode_r) begin
      opa = sub_r[trm_r];
      case (comp_r)
        2'd0:    opb = OPB_BITS'(vx_r[trm_r]);
        2'd1:    opb = OPB_BITS'(vy_r[trm_r]);
        default: opb = OPB_BITS'(vz_r[trm_r]);
      endcase
    end else begin
      case (sum_r)
        2'd0: begin
          opa  = DET_BITS'(trm_r[0] ? d_cy : d_by);
          opb  = OPB_BITS'(trm_r[0] ? d_bz : d_cz);
          osub = trm_r[0];
        end
        2'd1: begin
          opa  = DET_BITS'(trm_r[0] ? d_cy : d_ay);
          opb  = OPB_BITS'(trm_r[0] ? d_az : d_cz);
          osub = trm_r[0];
        end
        2'd2: begin
          opa  = DET_BITS'(trm_r[0] ? d_by : d_ay);
          opb  = OPB_BITS'(trm_r[0] ? d_az : d_bz);
          osub = trm_r[0];
        end
        default: begin
          case (trm_r)
            2'd0: begin
              opa = m1_r;
              opb = OPB_BITS'(d_ax);
            end
            2'd1: begin
              opa  = m2_r;
              opb  = OPB_BITS'(d_bx);
              osub = 1'b1;
            end
            default: begin
              opa = m3_r;
              opb = OPB_BITS'(d_cx);
            end
          endcase
        end
      endcase
    end
    if (mode_r) begin
      last_trm = (trm_r == (tri_mode ? 2'd2 : 2'd3));
    end else if (sum_r == 2'd3) begin
      last_trm = (trm_r == 2'd2);
    end else begin
      last_trm = (trm_r == 2'd1);
    end
  end

  // Status, with degenerate taking precedence over too small over outside.
  always_comb begin
    det_mag = det_r[DET_BITS-1] ? DET_BITS'(-det_r) : DET_BITS'(det_r);
    if ($signed(det_r) < $signed({1'b0, minv_r})) begin
      status_w = STAT_DEGENERATE;
    end else if (det_mag <= {1'b0, cut_r}) begin
      status_w = STAT_TOO_SMALL;
    end else if (outside_r) begin
      status_w = STAT_OUTSIDE;
    end else begin
      status_w = STAT_VALID;
    end
    // Saturate the quotient magnitude to the signed value range.
    lim     = neg_r ? HALF : HALF - ACC_BITS'(1);
    qs      = (acc_w > lim) ? lim[31:0] : acc_w[31:0];
    res_div = neg_r ? 32'd0 - qs : qs;
  end

  // Sequencer.
  always_comb begin
    st_nxt        = st_r;
    dk_nxt        = dk_r;
    sum_nxt       = sum_r;
    trm_nxt       = trm_r;
    ph_nxt        = ph_r;
    mode_nxt      = mode_r;
    comp_nxt      = comp_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    outside_nxt   = outside_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    qz_nxt        = qz_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    m3_nxt        = m3_r;
    det_nxt       = det_r;
    sub_nxt       = sub_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    sval          = $signed(acc_w[DET_BITS-1:0]);
    res_w         = res_div;
    cmd.op        = ARITH_NOP;
    cmd.a         = opa;
    cmd.b         = opb;
    cmd.sub       = osub;
    unique case (st_r)
      ST_IDLE: begin
        if (accept && in_data.action == ACT_QUERY) begin
          qx_nxt      = CW'(in_data.coord_x);
          qy_nxt      = CW'(in_data.coord_y);
          qz_nxt      = CW'(in_data.coord_z);
          dk_nxt      = 3'd0;
          sum_nxt     = tri_mode ? 2'd2 : 2'd0;
          trm_nxt     = 2'd0;
          ph_nxt      = 1'b0;
          mode_nxt    = 1'b0;
          outside_nxt = 1'b0;
          st_nxt      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.op = ph_r ? ARITH_MUL_HI : ARITH_MUL_LO;
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (last_trm) begin
            st_nxt = ST_DRAIN;
          end else begin
            trm_nxt = trm_r + 2'd1;
          end
        end
      end
      ST_DRAIN: begin
        st_nxt = mode_r ? ST_ISTO : ST_STORE;
      end
      ST_STORE: begin
        cmd.op  = ARITH_CLR;
        trm_nxt = 2'd0;
        st_nxt  = ST_MUL;
        case (sum_r)
          2'd0:    m1_nxt = sval;
          2'd1:    m2_nxt = sval;
          2'd2:    m3_nxt = sval;
          default: ;
        endcase
        if (sum_r == 2'd3 || tri_mode) begin
          if (dk_r == 3'd0) begin
            det_nxt = sval;
          end else begin
            sub_nxt[sidx] = sval;
            if ((!det_r[DET_BITS-1] && det_r != '0 && sval[DET_BITS-1]) ||
                (det_r[DET_BITS-1] && !sval[DET_BITS-1] && sval != '0)) begin
              outside_nxt = 1'b1;
            end
          end
          if (dk_r == dk_last) begin
            mode_nxt = 1'b1;
            comp_nxt = 2'd0;
          end else begin
            dk_nxt  = dk_r + 3'd1;
            sum_nxt = tri_mode ? 2'd2 : 2'd0;
          end
        end else begin
          sum_nxt = sum_r + 2'd1;
        end
      end
      ST_ISTO: begin
        neg_nxt = acc_w[ACC_BITS-1] ^ det_r[DET_BITS-1];
        cnt_nxt = '0;
        if (det_r == '0) begin
          // A zero determinant gives a zero field.
          cmd.op = ARITH_CLR;
          res_w  = '0;
        end else begin
          cmd.op = ARITH_DIV_INIT;
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op  = ARITH_DIV_STEP;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          st_nxt = ST_DFIN;
        end
      end
      ST_DFIN: begin
        cmd.op = ARITH_CLR;
      end
      default: st_nxt = ST_IDLE;
    endcase
    // A component is finished at the end of division, or at once when the
    // determinant is zero.
    if (st_r == ST_DFIN || (st_r == ST_ISTO && det_r == '0)) begin
      case (comp_r)
        2'd0:    out_data_nxt.result_x = res_w;
        2'd1:    out_data_nxt.result_y = res_w;
        default: out_data_nxt.result_z = res_w;
      endcase
      if (comp_r == 2'd2) begin
        out_data_nxt.status      = status_w;
        out_data_nxt.element_det = det_r;
        out_valid_nxt            = 1'b1;
        st_nxt                   = ST_IDLE;
      end else begin
        comp_nxt = comp_r + 2'd1;
        trm_nxt  = 2'd0;
        ph_nxt   = 1'b0;
        st_nxt   = ST_MUL;
      end
    end
  end

  always_ff @(posedge clk) begin
    dk_r       <= dk_nxt;
    sum_r      <= sum_nxt;
    trm_r      <= trm_nxt;
    ph_r       <= ph_nxt;
    mode_r     <= mode_nxt;
    comp_r     <= comp_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    outside_r  <= outside_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    qz_r       <= qz_nxt;
    m1_r       <= m1_nxt;
    m2_r       <= m2_nxt;
    m3_r       <= m3_nxt;
    det_r      <= det_nxt;
    sub_r      <= sub_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  sbi_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .divisor (det_mag),
    .acc     (acc_w)
  );

  assign busy      = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SBI_ASSERT_IMP(a_out_after_last, out_valid_r, $past(st_r == ST_DFIN || st_r == ST_ISTO), "result strobe without a finished component")
  `SBI_ASSERT_NXT(a_load_no_busy, accept && in_data.action == ACT_LOAD, !busy, "a corner load started a query")
  `SBI_ASSERT_IMP(a_div_nonzero, st_r == ST_DIV, det_r != '0, "division by a zero determinant")

endmodule

@@ dv/simplex_barycentric_interpolator_unit_tb.sv @@
// Self-checking testbench for the simplex barycentric interpolator unit.
`timescale 1ns / 1ps

module simplex_barycentric_interpolator_unit_tb;
  import sbi_pkg::*;

  // The settle time after the last transaction is a little longer than a
  // query runs in 3D.
  localparam int QUERY_CYCLES = 600;
  localparam logic [62:0] CFG_MAX = {63{1'b1}};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  simplex_barycentric_interpolator_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Mirror of the block's registers and corner store.
  logic [1:0]  dim_reg;
  logic [62:0] cut_reg;
  logic [62:0] minvol_reg;
  longint      corner_x[4], corner_y[4], corner_z[4];
  longint      field_x[4], field_y[4], field_z[4];

  out_item_t   pending_results[$];
  int          fail_count;
  bit          no_gap_run;

  // Raw determinant of the simplex; in 2D only corners 0..2 in y-z count.
  function automatic longint simplex_volume(longint px[4], longint py[4], longint pz[4],
                                            bit tri_mode);
    longint ax, ay, az, bx, by, bz, qx, qy, qz;
    ax = px[1] - px[0]; ay = py[1] - py[0]; az = pz[1] - pz[0];
    bx = px[2] - px[0]; by = py[2] - py[0]; bz = pz[2] - pz[0];
    qx = px[3] - px[0]; qy = py[3] - py[0]; qz = pz[3] - pz[0];
    if (tri_mode) begin
      return ay * bz - by * az;
    end
    return ax * (by * qz - qy * bz) - bx * (ay * qz - qy * az) + qx * (ay * bz - by * az);
  endfunction

  // Weighted sum of the corner field, divided once by the determinant with
  // truncation toward zero and clamped to the 32-bit signed range.
  function automatic logic signed [31:0] blend_field(longint w[4], longint f[4], int n,
                                                     longint det);
    logic signed [127:0] acc, wi, fi, quo, dd;
    acc = '0;
    if (det == 0) begin
      return '0;
    end
    for (int i = 0; i < n; i++) begin
      wi = w[i];
      fi = f[i];
      acc = acc + wi * fi;
    end
    dd = det;
    quo = acc / dd;
    if (quo > 128'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (quo < -128'sd2147483648) begin
      return 32'sh80000000;
    end
    return quo[31:0];
  endfunction

  // Updates the corner store for a load, or works out the result of a query.
  task automatic predict_transaction(in_item_t t);
    longint    px[4], py[4], pz[4], w[4];
    longint    det;
    longint    det_mag;
    bit        tri_mode, outside;
    int        n;
    out_item_t r;
    if (t.action == ACT_LOAD) begin
      corner_x[t.corner_slot] = t.coord_x;
      corner_y[t.corner_slot] = t.coord_y;
      corner_z[t.corner_slot] = t.coord_z;
      field_x[t.corner_slot]  = t.value_x;
      field_y[t.corner_slot]  = t.value_y;
      field_z[t.corner_slot]  = t.value_z;
      return;
    end
    tri_mode = (dim_reg == 2'd2);
    n = tri_mode ? 3 : 4;
    det = simplex_volume(corner_x, corner_y, corner_z, tri_mode);
    outside = 1'b0;
    w = '{0, 0, 0, 0};
    for (int i = 0; i < n; i++) begin
      px = corner_x; py = corner_y; pz = corner_z;
      px[i] = t.coord_x; py[i] = t.coord_y; pz[i] = t.coord_z;
      w[i] = simplex_volume(px, py, pz, tri_mode);
      if ((det > 0 && w[i] < 0) || (det < 0 && w[i] > 0)) begin
        outside = 1'b1;
      end
    end
    det_mag = (det < 0) ? -det : det;
    // Degenerate wins over too small, which wins over outside.
    if (det < longint'({1'b0, minvol_reg})) begin
      r.status = STAT_DEGENERATE;
    end else if (det_mag <= longint'({1'b0, cut_reg})) begin
      r.status = STAT_TOO_SMALL;
    end else if (outside) begin
      r.status = STAT_OUTSIDE;
    end else begin
      r.status = STAT_VALID;
    end
    r.result_x = blend_field(w, field_x, n, det);
    r.result_y = blend_field(w, field_y, n, det);
    r.result_z = blend_field(w, field_z, n, det);
    r.element_det = det;
    pending_results.push_back(r);
  endtask

  // Results are sampled mid-cycle, while out_valid and out_data are stable.
  always @(negedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction status %0d", out_data.status);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          fail_count++;
        end
        if (out_data.result_x !== e.result_x) begin
          $error("result_x expected %0d actual %0d", e.result_x, out_data.result_x);
          fail_count++;
        end
        if (out_data.result_y !== e.result_y) begin
          $error("result_y expected %0d actual %0d", e.result_y, out_data.result_y);
          fail_count++;
        end
        if (out_data.result_z !== e.result_z) begin
          $error("result_z expected %0d actual %0d", e.result_z, out_data.result_z);
          fail_count++;
        end
        if (out_data.element_det !== e.element_det) begin
          $error("element_det expected %0d actual %0d", e.element_det,
                 out_data.element_det);
          fail_count++;
        end
      end
    end
  end

  // Sends one transaction. The task starts and ends on a rising edge; start is
  // only lowered when a gap is actually inserted, so it never drops and rises
  // within one time step.
  task automatic send_item(in_item_t t);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      no_gap_run = !no_gap_run;
    end
    gap = no_gap_run ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= t;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_transaction(t);
  endtask

  // Holds off the sender until every expected result has come and the block
  // has had time to finish.
  task automatic drain_block();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [62:0] val);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_DIMENSION:  dim_reg    = val[1:0];
      CFG_VOLUME_CUT: cut_reg    = val;
      CFG_MIN_VOLUME: minvol_reg = val;
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(logic act, logic [1:0] slot, int x, int y, int z,
                                         int fx, int fy, int fz);
    in_item_t t;
    t.action = act; t.corner_slot = slot;
    t.coord_x = 16'(x); t.coord_y = 16'(y); t.coord_z = 16'(z);
    t.value_x = fx; t.value_y = fy; t.value_z = fz;
    return t;
  endfunction

  task automatic load_unit_tetra(int fx, int fy, int fz);
    send_item(make_item(ACT_LOAD, 2'd0, 0, 0, 0, fx, fy, fz));
    send_item(make_item(ACT_LOAD, 2'd1, 1, 0, 0, -fx, fz, fy));
    send_item(make_item(ACT_LOAD, 2'd2, 0, 1, 0, fy, -fx, fz));
    send_item(make_item(ACT_LOAD, 2'd3, 0, 0, 1, fz, fy, -fy));
  endtask

  // Reset defaults, corner queries, an outside point with clamping and a
  // flat element.
  task automatic test_directed();
    load_unit_tetra(32'sh7fffffff, -32'sh80000000, 1000);
    send_item(make_item(ACT_QUERY, 2'd0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_QUERY, 2'd3, 0, 0, 1, -1, -1, -1));
    send_item(make_item(ACT_QUERY, 2'd1, 32767, 32767, 32767, 0, 0, 0));
    send_item(make_item(ACT_QUERY, 2'd2, -32768, -32768, -32768, 0, 0, 0));
    // Large element at the coordinate extremes with extreme field values.
    send_item(make_item(ACT_LOAD, 2'd0, -32768, -32768, -32768, -32'sh80000000,
                        32'sh7fffffff, 0));
    send_item(make_item(ACT_LOAD, 2'd1, 32767, -32768, -32768, 32'sh7fffffff,
                        -32'sh80000000, -1));
    send_item(make_item(ACT_LOAD, 2'd2, -32768, 32767, -32768, 12345, -7, 32'sh7fffffff));
    send_item(make_item(ACT_LOAD, 2'd3, -32768, -32768, 32767, -1, 1, -32'sh80000000));
    send_item(make_item(ACT_QUERY, 2'd0, -100, -200, -300, 0, 0, 0));
    send_item(make_item(ACT_QUERY, 2'd0, 32767, 32767, 32767, 0, 0, 0));
    // Swapping two corners flips the sign and makes the element degenerate.
    send_item(make_item(ACT_LOAD, 2'd3, -32768, 32767, -32768, 12345, -7, 32'sh7fffffff));
    send_item(make_item(ACT_LOAD, 2'd2, -32768, -32768, 32767, -1, 1, -32'sh80000000));
    send_item(make_item(ACT_QUERY, 2'd0, 0, 0, 0, 0, 0, 0));
    // All corners equal: zero determinant and a zero field.
    for (int s = 0; s < 4; s++) begin
      send_item(make_item(ACT_LOAD, s[1:0], 5, 5, 5, 99, 98, 97));
    end
    send_item(make_item(ACT_QUERY, 2'd0, 5, 5, 5, 0, 0, 0));
    drain_block();
  endtask

  // Walks every register through its extremes, including all dimension codes.
  task automatic test_register_sweep();
    logic [62:0] cuts[3];
    logic [62:0] mins[3];
    cuts = '{63'd0, 63'd3, CFG_MAX};
    mins = '{63'd0, 63'd1, CFG_MAX};
    for (int d = 0; d < 4; d++) begin
      write_reg(CFG_DIMENSION, 63'(d));
      for (int k = 0; k < 3; k++) begin
        write_reg(CFG_VOLUME_CUT, cuts[k]);
        write_reg(CFG_MIN_VOLUME, mins[(k + d) % 3]);
        load_unit_tetra(3000, -3000, 77);
        send_item(make_item(ACT_QUERY, 2'd0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_LOAD, 2'd2, 0, 0, 1, 5, 6, 7));
        send_item(make_item(ACT_QUERY, 2'd1, 0, 1, -1, 0, 0, 0));
      end
    end
    write_reg(CFG_VOLUME_CUT, 63'd0);
    write_reg(CFG_MIN_VOLUME, 63'd0);
  endtask

  function automatic int rand_coord(int span);
    if (span >= 32768) begin
      return $signed(16'($urandom));
    end
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Loads a full element in random order, then queries it mostly with points
  // inside it; a few stray loads are mixed in.
  task automatic test_random_elements(int budget);
    int     sent, span, order[4], nq, wsum, wt[4];
    longint sx, sy, sz;
    sent = 0;
    while (sent < budget) begin
      if (sent % 120 < 12) begin
        case ($urandom_range(0, 3))
          0: write_reg(CFG_DIMENSION, 63'($urandom_range(0, 3)));
          1: write_reg(CFG_VOLUME_CUT, $urandom_range(0, 1) ? 63'($urandom_range(0, 1 << 20))
                                                         : 63'd0);
          2: write_reg(CFG_MIN_VOLUME, $urandom_range(0, 3) == 0 ? CFG_MAX
                                                                : 63'($urandom_range(0, 2)));
          default: ;
        endcase
      end
      case ($urandom_range(0, 2))
        0: span = 50;
        1: span = 2000;
        default: span = 32768;
      endcase
      order = '{0, 1, 2, 3};
      order.shuffle();
      for (int i = 0; i < 4; i++) begin
        send_item(make_item(ACT_LOAD, order[i][1:0], rand_coord(span), rand_coord(span),
                            rand_coord(span), $urandom, $urandom, $urandom));
      end
      sent += 4;
      nq = $urandom_range(1, 6);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(make_item(ACT_LOAD, 2'($urandom), rand_coord(span), rand_coord(span),
                              rand_coord(span), $urandom, $urandom, $urandom));
          sent++;
        end
        if ($urandom_range(0, 9) < 6) begin
          wsum = 0; sx = 0; sy = 0; sz = 0;
          for (int i = 0; i < 4; i++) begin
            wt[i] = $urandom_range(0, 15);
            if (dim_reg == 2'd2 && i == 3) wt[i] = 0;
            wsum += wt[i];
            sx += wt[i] * corner_x[i]; sy += wt[i] * corner_y[i]; sz += wt[i] * corner_z[i];
          end
          if (wsum == 0) begin
            wsum = 1;
          end
          send_item(make_item(ACT_QUERY, 2'($urandom), int'(sx / wsum), int'(sy / wsum),
                              int'(sz / wsum), $urandom, $urandom, $urandom));
        end else begin
          send_item(make_item(ACT_QUERY, 2'($urandom), rand_coord(span), rand_coord(span),
                              rand_coord(span), $urandom, $urandom, $urandom));
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    fail_count = 0;
    no_gap_run = 1'b0;
    dim_reg    = 2'd3;
    cut_reg    = '0;
    minvol_reg = 63'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_sweep();
    test_random_elements(745);
    drain_block();
    repeat (QUERY_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
